@@ design/umrt_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and types of the retransmit table
package umrt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int ID_W       = 32;
   localparam int STAMP_W    = 16;
   localparam int TIMEOUT_W  = 15;
   localparam int COUNT_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [OP_W-1:0] OP_SEND = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET    = 15'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_ADDR = 2'd0;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [STAMP_W-1:0] stamp;
   } umrt_entry_type;

endpackage

@@ design/umrt_entry_mem.sv @@
`timescale 1ns / 1ps
// entry store: message id and timestamp per slot, one write and one registered read port
module umrt_entry_mem import umrt_pkg::*; #(
   parameter int DEPTH  = TABLE_DEPTH_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  umrt_entry_type wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output umrt_entry_type rd_data
);

   umrt_entry_type entry_ff [DEPTH];
   umrt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/umrt_match_unit.sv @@
`timescale 1ns / 1ps
// shared compare unit: tests one entry against the current operation
module umrt_match_unit import umrt_pkg::*; (
   input  logic [OP_W-1:0]      op,
   input  logic                 valid,
   input  umrt_entry_type       entry,
   input  logic [ID_W-1:0]      ack_id,
   input  logic [STAMP_W-1:0]   cur_time,
   input  logic [TIMEOUT_W-1:0] timeout,
   output logic                 hit
);

   logic [STAMP_W-1:0] age;

   // age wraps modulo the stamp width
   assign age = cur_time - entry.stamp;

   always_comb begin
      case (op)
         OP_SEND: hit = !valid;
         OP_ACK:  hit = valid && (entry.id == ack_id);
         OP_TICK: hit = valid && (age > STAMP_W'(timeout));
         default: hit = 1'b0;
      endcase
   end

endmodule

@@ design/unacked_message_retransmit_table_unit.sv @@
`timescale 1ns / 1ps
// top level: unacknowledged message table with retransmission timer
//
// one command (send, ack or tick) is taken when start is high and busy is low; the
// table is then scanned one slot per cycle through a single compare unit, and the
// scan stops at the first slot that qualifies, or after the last slot if none
// qualifies. the time from the accept edge to the edge that takes the result word
// is set by the scan length over the entry memory's one read port. the result
// word is shown for exactly one cycle with rsp_valid high and cannot be held off;
// busy is already low in that cycle, so the next command may be accepted then. no
// clearing pass is needed after reset: only the valid bits are cleared.
// timeout_ticks is at byte address 0 and should be written only while idle
module unacked_message_retransmit_table_unit import umrt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ID_W-1:0]       req_ack_id,
   // result channel
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_retransmit,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [ID_W-1:0]       rsp_message_id,
   output logic [COUNT_W-1:0]    rsp_transmission_count,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      ack_ff, ack_in;
   logic [ID_W-1:0]      seq_ff, seq_in;
   logic [STAMP_W-1:0]   time_ff, time_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 cmp_live_ff, cmp_live_in;
   logic                 valid_ff [TABLE_DEPTH];
   logic                 valid_in [TABLE_DEPTH];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_retx_ff, rsp_retx_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]      rsp_mid_ff, rsp_mid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   umrt_entry_type       rd_entry;
   umrt_entry_type       wr_entry;
   logic                 wr_en;
   logic                 hit;
   logic                 decide;
   logic                 is_send;
   logic                 is_ack;
   logic                 is_tick;
   logic                 accept;
   logic                 csr_write;
   logic [EXT_W-1:0]     idx_ext;

   // entry store, read one slot per cycle during the scan
   umrt_entry_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmp_idx_ff),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   // the one compare unit, fed with the slot whose data just came back
   umrt_match_unit u_match (
      .op       (op_ff),
      .valid    (valid_ff[cmp_idx_ff]),
      .entry    (rd_entry),
      .ack_id   (ack_ff),
      .cur_time (time_ff),
      .timeout  (timeout_ff),
      .hit      (hit)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign is_send   = (op_ff == OP_SEND);
   assign is_ack    = (op_ff == OP_ACK);
   assign is_tick   = (op_ff == OP_TICK);

   // scan ends at the first qualifying slot or after the last slot
   assign decide = (state_ff == ST_SCAN) && cmp_live_ff && (hit || (cmp_idx_ff == LAST_IDX));

   // send stores a fresh id, a retransmit keeps its id; both restamp
   assign wr_en          = decide && hit && (is_send || is_tick);
   assign wr_entry.id    = is_send ? seq_ff : rd_entry.id;
   assign wr_entry.stamp = time_ff;

   // slot reports the low bits of the index
   assign idx_ext = EXT_W'(cmp_idx_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ack_in       = ack_ff;
      seq_in       = seq_ff;
      time_in      = time_ff;
      count_in     = count_ff;
      timeout_in   = timeout_ff;
      addr_in      = addr_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_live_in  = cmp_live_ff;
      valid_in     = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_retx_in   = rsp_retx_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_mid_in    = rsp_mid_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_write && (paddr == CSR_TIMEOUT_ADDR)) begin
         timeout_in = pwdata[TIMEOUT_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               ack_in      = req_ack_id;
               addr_in     = '0;
               cmp_live_in = 1'b0;
               // sequence id is used up even if the table turns out full
               if (req_operation == OP_SEND) begin
                  seq_in = seq_ff + 1'b1;
               end
               if (req_operation == OP_TICK) begin
                  time_in = time_ff + 1'b1;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in     = (addr_ff == LAST_IDX) ? addr_ff : addr_ff + 1'b1;
            cmp_idx_in  = addr_ff;
            cmp_live_in = 1'b1;
            if (decide) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_retx_in   = 1'b0;
               rsp_slot_in   = '0;
               rsp_mid_in    = '0;
               if (is_send && !hit) begin
                  rsp_status_in = STATUS_FULL;
               end
               if (is_ack && !hit) begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
               if (hit && is_ack) begin
                  valid_in[cmp_idx_ff] = 1'b0;
               end
               if (hit && (is_send || is_tick)) begin
                  rsp_slot_in = idx_ext[SLOT_W-1:0];
                  rsp_mid_in  = wr_entry.id;
                  rsp_retx_in = is_tick;
                  count_in    = count_ff + 1'b1;
                  if (is_send) begin
                     valid_in[cmp_idx_ff] = 1'b1;
                  end
               end
               rsp_count_in = (hit && (is_send || is_tick)) ? count_ff + 1'b1 : count_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         time_ff      <= '0;
         count_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         cmp_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         time_ff      <= time_in;
         count_ff     <= count_in;
         timeout_ff   <= timeout_in;
         cmp_live_ff  <= cmp_live_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      op_ff         <= op_in;
      ack_ff        <= ack_in;
      addr_ff       <= addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_retx_ff   <= rsp_retx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_mid_ff    <= rsp_mid_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // register readback
   assign prdata = (paddr == CSR_TIMEOUT_ADDR) ? CSR_DATA_W'(timeout_ff) : '0;
   assign pready = 1'b1;

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_retransmit         = rsp_retx_ff;
   assign rsp_slot               = rsp_slot_ff;
   assign rsp_message_id         = rsp_mid_ff;
   assign rsp_transmission_count = rsp_count_ff;

endmodule

@@ design/umrt_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the retransmit table, bound to the top level
module umrt_checker import umrt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic                  rsp_retransmit,
   input logic [ID_W-1:0]       rsp_message_id,
   input logic [COUNT_W-1:0]    rsp_transmission_count
);

   // an accepted word keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // a result ends every command, and only then
   a_result_ends_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $fell(busy))
      else $error("result strobe not aligned with end of command");

   // failed commands carry no message id and no retransmit
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_DONE) |-> !rsp_retransmit && (rsp_message_id == '0))
      else $error("failed command reports a message");

   // the transmission count moves by at most one per result
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid, 3) |->
         (rsp_transmission_count - $past(rsp_transmission_count, 3)) <= COUNT_W'(1))
      else $error("transmission count jumped");

endmodule

bind unacked_message_retransmit_table_unit umrt_checker u_umrt_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .rsp_valid              (rsp_valid),
   .rsp_status             (rsp_status),
   .rsp_retransmit         (rsp_retransmit),
   .rsp_message_id         (rsp_message_id),
   .rsp_transmission_count (rsp_transmission_count)
);
